// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the power-supply fault supervisor.
// ----------------------------------------------------------------------------
package pfs_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam int STATE_WIDTH = 4;
    localparam int CMD_WIDTH   = 2;
    localparam int ADDR_WIDTH  = 2;

    localparam int IN_TDATA_WIDTH  = 16;
    localparam int OUT_TDATA_WIDTH = 8;

    // supervisor states
    localparam logic [STATE_WIDTH-1:0] ST_INIT   = 4'd0;
    localparam logic [STATE_WIDTH-1:0] ST_IDLE   = 4'd1;
    localparam logic [STATE_WIDTH-1:0] ST_NORMAL = 4'd2;
    localparam logic [STATE_WIDTH-1:0] ST_VOUT   = 4'd3;
    localparam logic [STATE_WIDTH-1:0] ST_VIN    = 4'd4;
    localparam logic [STATE_WIDTH-1:0] ST_OLP    = 4'd5;
    localparam logic [STATE_WIDTH-1:0] ST_SC     = 4'd6;
    localparam logic [STATE_WIDTH-1:0] ST_HALT   = 4'd7;
    localparam logic [STATE_WIDTH-1:0] ST_OFF    = 4'd8;

    // power commands
    localparam logic [CMD_WIDTH-1:0] CMD_NONE = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_ON   = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_OFF  = 2'd2;

    // config register indexes
    localparam logic [ADDR_WIDTH-1:0] CFG_SHORT_TIMEOUT = 2'd0;
    localparam logic [ADDR_WIDTH-1:0] CFG_VOUT_TIMEOUT  = 2'd1;
    localparam logic [ADDR_WIDTH-1:0] CFG_HICCUP_TICKS  = 2'd2;

    localparam logic [CFG_WIDTH-1:0] SHORT_TIMEOUT_RST = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] VOUT_TIMEOUT_RST  = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] HICCUP_TICKS_RST  = 16'd3000;

    typedef struct packed {
        logic                 efuse_tripped;
        logic                 efuse_active;
        logic                 iout_short;
        logic                 iout_over;
        logic                 iout_good;
        logic                 vout_good;
        logic                 vin_under;
        logic                 vin_over;
        logic                 vin_good;
    } t_pfs_flags;

    typedef struct packed {
        logic [STATE_WIDTH-1:0] fsm_state;
        logic                   buck_on;
        logic [COUNT_WIDTH-1:0] short_cnt;
        logic [COUNT_WIDTH-1:0] vout_cnt;
        logic [COUNT_WIDTH-1:0] halt_cnt;
    } t_pfs_regs;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_timeout;
        logic [CFG_WIDTH-1:0] vout_timeout;
        logic [CFG_WIDTH-1:0] hiccup_ticks;
    } t_pfs_cfg;

endpackage

// ----- hdl/psu_fault_supervisor_fsm.sv -----
// ----------------------------------------------------------------------------
// psu_fault_supervisor_fsm
// Power-supply fault supervisor stepped once per streamed tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one supervision tick carrying the
//   supply flags and a pending power command. Each tick yields one transfer on
//   m_axis with the new supervisor state, buck enable and an efuse-reset pulse.
//   m_axis_tvalid rises in the cycle after the input transfer.
//   Throughput: 1 tick per cycle unless stalled; the state, counters and result
//   register all update in the cycle the tick is taken, so consecutive ticks
//   chain directly. The single result register sets the rate: s_axis_tready
//   is high while that register is empty or being drained in the same cycle.
//   Stall: while m_axis_tready is low with a result held, the result stays put
//   and s_axis_tready drops; no tick is lost or repeated.
//   Reset (i_rst_n low, synchronous): state to init, buck off, all counters
//   zero, output empty, timeouts back to 1000/1000/3000 ticks.
//   Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
//   (0 short timeout, 1 vout timeout, 2 hiccup ticks); index 3 is ignored.
//   Write only while no tick is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psu_fault_supervisor_fsm import pfs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_we,
    input  logic [ADDR_WIDTH-1:0]      i_cfg_addr,
    input  logic [CFG_WIDTH-1:0]       i_cfg_wdata,

    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // [0] vin_good [1] vin_over [2] vin_under [3] vout_good [4] iout_good
    // [5] iout_over [6] iout_short [7] efuse_active [8] efuse_tripped
    // [10:9] power_cmd, [15:11] zero
    input  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata,

    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [3:0] supervisor_state [4] buck_enable [5] efuse_reset, [7:6] zero
    output logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    t_pfs_cfg                     r_cfg;
    t_pfs_regs                    r_regs;
    logic                         r_out_valid;
    logic [OUT_TDATA_WIDTH-1:0]   r_out_data;

    t_pfs_regs                    n_regs;
    logic                         n_efr;
    t_pfs_flags                   in_flags;
    logic [CMD_WIDTH-1:0]         in_cmd;
    logic                         in_xfer;

    assign in_flags = s_axis_tdata[8:0];
    assign in_cmd   = s_axis_tdata[10:9];

    // result register empty or draining this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_timeout <= SHORT_TIMEOUT_RST;
            r_cfg.vout_timeout  <= VOUT_TIMEOUT_RST;
            r_cfg.hiccup_ticks  <= HICCUP_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SHORT_TIMEOUT: r_cfg.short_timeout <= i_cfg_wdata;
                CFG_VOUT_TIMEOUT:  r_cfg.vout_timeout  <= i_cfg_wdata;
                CFG_HICCUP_TICKS:  r_cfg.hiccup_ticks  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    pfs_step u_step (
        .i_cur         (r_regs),
        .i_cfg         (r_cfg),
        .i_flags       (in_flags),
        .i_cmd         (in_cmd),
        .o_nxt         (n_regs),
        .o_efuse_reset (n_efr)
    );

    // supervisor state advances on every accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.fsm_state <= ST_INIT;
            r_regs.buck_on   <= 1'b0;
            r_regs.short_cnt <= '0;
            r_regs.vout_cnt  <= '0;
            r_regs.halt_cnt  <= '0;
        end else if (in_xfer) begin
            r_regs <= n_regs;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= {2'b00, n_efr, n_regs.buck_on, n_regs.fsm_state};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `ASSERT_NEXT(a_xfer_gives_result, i_clk, i_rst_n, in_xfer, m_axis_tvalid)
    `ASSERT_PROP(a_efr_only_to_run, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tdata[5]) ||
        (m_axis_tdata[3:0] == ST_NORMAL) || (m_axis_tdata[3:0] == ST_IDLE))
    `ASSERT_PROP(a_halt_cnt_idle, i_clk, i_rst_n,
        (r_regs.fsm_state == ST_HALT) || (r_regs.halt_cnt == '0))
    `ASSERT_PROP(a_fault_cnt_idle, i_clk, i_rst_n,
        ((r_regs.fsm_state == ST_SC) || (r_regs.short_cnt == '0)) &&
        ((r_regs.fsm_state == ST_VOUT) || (r_regs.vout_cnt == '0)))
    `ASSERT_NEXT(a_cmd_off_wins, i_clk, i_rst_n,
        in_xfer && (in_cmd == CMD_OFF), !r_regs.buck_on)

endmodule

// ----- hdl/pfs_step.sv -----
// ----------------------------------------------------------------------------
// pfs_step
// Next-state logic of the supervisor for one tick, power command included.
// ----------------------------------------------------------------------------
module pfs_step import pfs_pkg::*; (
    input  t_pfs_regs              i_cur,
    input  t_pfs_cfg               i_cfg,
    input  t_pfs_flags             i_flags,
    input  logic [CMD_WIDTH-1:0]   i_cmd,
    output t_pfs_regs              o_nxt,
    output logic                   o_efuse_reset
);

    t_pfs_regs              n_regs;
    logic                   n_efr;
    logic                   vin_clean;
    logic                   out_ok;
    logic [COUNT_WIDTH-1:0] short_inc;
    logic [COUNT_WIDTH-1:0] vout_inc;
    logic [COUNT_WIDTH-1:0] halt_inc;

    assign vin_clean = i_flags.vin_good && !i_flags.vin_over && !i_flags.vin_under &&
                       !i_flags.efuse_active && !i_flags.efuse_tripped;
    assign out_ok    = i_flags.vout_good && i_flags.iout_good && !i_flags.iout_short;

    // counters wrap at COUNT_WIDTH
    assign short_inc = i_cur.short_cnt + 1'b1;
    assign vout_inc  = i_cur.vout_cnt  + 1'b1;
    assign halt_inc  = i_cur.halt_cnt  + 1'b1;

    always_comb begin
        n_regs = i_cur;
        n_efr  = 1'b0;
        unique case (i_cur.fsm_state) inside
            ST_IDLE, ST_VIN: begin
                if (vin_clean) begin
                    n_regs.buck_on   = 1'b1;
                    n_efr            = 1'b1;
                    n_regs.fsm_state = ST_NORMAL;
                end
            end
            ST_NORMAL: begin
                if (!i_flags.vout_good && !i_flags.iout_good && i_flags.iout_short) begin
                    n_regs.fsm_state = ST_SC;
                end else if (!i_flags.vin_good) begin
                    n_regs.buck_on   = 1'b0;
                    n_regs.fsm_state = ST_VIN;
                end else if (!i_flags.vout_good) begin
                    n_regs.fsm_state = ST_VOUT;
                end else if (i_flags.iout_good && i_flags.iout_over &&
                             i_flags.efuse_active) begin
                    n_regs.fsm_state = ST_OLP;
                end else if (!i_cur.buck_on) begin
                    n_regs.fsm_state = ST_OFF;
                end
            end
            ST_VOUT: begin
                n_regs.vout_cnt = vout_inc;
                if (out_ok) begin
                    n_regs.vout_cnt  = '0;
                    n_regs.fsm_state = ST_NORMAL;
                end else if (CMP_WIDTH'(vout_inc) > CMP_WIDTH'(i_cfg.vout_timeout)) begin
                    n_regs.vout_cnt  = '0;
                    n_regs.buck_on   = 1'b0;
                    n_regs.fsm_state = ST_HALT;
                end
            end
            ST_OLP: begin
                if (i_flags.efuse_active && i_flags.efuse_tripped) begin
                    // trip: halt with the buck left as is
                    n_regs.fsm_state = ST_HALT;
                end else if (!i_flags.efuse_active) begin
                    n_efr            = 1'b1;
                    n_regs.fsm_state = ST_NORMAL;
                end
            end
            ST_SC: begin
                n_regs.short_cnt = short_inc;
                if (out_ok) begin
                    n_regs.short_cnt = '0;
                    n_efr            = 1'b1;
                    n_regs.fsm_state = ST_NORMAL;
                end else if (CMP_WIDTH'(short_inc) > CMP_WIDTH'(i_cfg.short_timeout)) begin
                    n_regs.short_cnt = '0;
                    n_regs.buck_on   = 1'b0;
                    n_regs.fsm_state = ST_HALT;
                end
            end
            ST_HALT: begin
                n_regs.halt_cnt = halt_inc;
                if (halt_inc == COUNT_WIDTH'(i_cfg.hiccup_ticks)) begin
                    n_regs.halt_cnt  = '0;
                    n_efr            = 1'b1;
                    n_regs.buck_on   = 1'b1;
                    n_regs.fsm_state = ST_NORMAL;
                end
            end
            ST_OFF: begin
                if (i_flags.vin_good && i_cur.buck_on) begin
                    n_regs.fsm_state = ST_INIT;
                end
            end
            default: begin
                // init and unused codes
                n_efr            = 1'b1;
                n_regs.fsm_state = ST_IDLE;
            end
        endcase

        // pending command wins over the state machine's buck decision
        if (i_cmd == CMD_ON) begin
            n_regs.buck_on = 1'b1;
        end else if (i_cmd == CMD_OFF) begin
            n_regs.buck_on = 1'b0;
        end
    end

    assign o_nxt         = n_regs;
    assign o_efuse_reset = n_efr;

endmodule
